// ----- rtl/ridge_mark_2x2_window_macros.svh -----
// assertion macros shared by the ridge marker rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef RIDGE_MARK_2X2_WINDOW_MACROS_SVH
`define RIDGE_MARK_2X2_WINDOW_MACROS_SVH
`ifndef SYNTHESIS
`define RMARK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rmark assertion failed");
`define RMARK_ASSERT_NOW(lbl, pre, post) `RMARK_ASSERT(lbl, (pre) |-> (post))
`define RMARK_ASSERT_NEXT(lbl, pre, post) `RMARK_ASSERT(lbl, (pre) |=> (post))
`else
`define RMARK_ASSERT(lbl, prop)
`define RMARK_ASSERT_NOW(lbl, pre, post)
`define RMARK_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- rtl/rmark_pkg.sv -----
// types and constants of the 2x2 ridge marker
// no dependencies
package rmark_pkg;

  localparam int ELEV_W        = 32;
  localparam int ROW_W         = 16;
  localparam int COL_W         = 10;
  localparam int GW_W          = 11;
  localparam int GH_W          = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam logic [GW_W-1:0] GW_RESET = GW_W'(1024);
  localparam logic [GH_W-1:0] GH_RESET = GH_W'(1024);
  localparam logic [GH_W-1:0] GH_MIN   = GH_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_idx_e;

  // result slots of one window, in raster order
  typedef enum logic [1:0] {
    SLOT_UP_LEFT   = 2'd0,
    SLOT_UP_RIGHT  = 2'd1,
    SLOT_LOW_LEFT  = 2'd2,
    SLOT_LOW_RIGHT = 2'd3
  } slot_e;

  typedef struct packed {
    logic signed [ELEV_W-1:0] elevation;
    logic                     present;
    logic                     flag;
  } point_t;

endpackage

// ----- rtl/rmark_in_if.sv -----
// sample request channel of the ridge marker
// depends on rmark_pkg
interface rmark_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmark_pkg::ELEV_W-1:0]  elevation;
  logic                                 present;

  modport source (output valid, elevation, present, input ready);
  modport sink (input valid, elevation, present, output ready);
endinterface

// ----- rtl/rmark_out_if.sv -----
// result request channel of the ridge marker
// depends on rmark_pkg
interface rmark_out_if;
  logic                         valid;
  logic                         ready;
  logic [rmark_pkg::ROW_W-1:0]  row;
  logic [rmark_pkg::COL_W-1:0]  column;
  logic                         ridge_flag;
  logic                         last;

  modport source (output valid, row, column, ridge_flag, last, input ready);
  modport sink (input valid, row, column, ridge_flag, last, output ready);
endinterface

// ----- rtl/ridge_mark_2x2_window.sv -----
// top level of the 2x2 highest point ridge marker
// depends on rmark_pkg, rmark_in_if, rmark_out_if, rmark_ram and the macros header
//
//   port        direction  carries
//   in_i        sink       elevation and present bit, raster order
//   out_o       source     row, column, ridge flag, last of a final point
//   cfg_we_i    input      register write: index 0 grid width, 1 grid height
//
// an accepted item is held in the window stage, then its results in the result buffer.
// one sample per cycle while a sample yields at most one result and out_o is ready; a
// row end sample yields two, a bottom row sample two (four at the row end); the single
// output port sets the pace. line store read and write share one ram with registered
// read, writes to the entry being read are forwarded. reset needs no clearing pass.
`include "ridge_mark_2x2_window_macros.svh"

module ridge_mark_2x2_window #(
  parameter int MAX_WIDTH = rmark_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rmark_in_if.sink                         in_i,
  rmark_out_if.source                      out_o,
  input  logic                             cfg_we_i,
  input  logic [rmark_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rmark_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WN = $clog2(MAX_WIDTH + 1);
  localparam int WW = (WN > rmark_pkg::GW_W) ? WN : rmark_pkg::GW_W;
  localparam int PW = $bits(rmark_pkg::point_t);

  // configuration
  logic [rmark_pkg::GW_W-1:0]  gw_q, gw_d;
  logic [rmark_pkg::GH_W-1:0]  gh_q, gh_d;
  logic                        restart;
  logic [WW-1:0]               gw_ext, eff_w;
  logic [CW-1:0]               last_col;
  logic [rmark_pkg::ROW_W-1:0] last_row;

  // input position
  logic [CW-1:0]               col_q, col_d;
  logic [rmark_pkg::ROW_W-1:0] row_q, row_d;
  logic                        in_fire;
  logic                        in_row_end, in_bottom;

  // window stage
  logic                        s1_valid_q, s1_valid_d;
  rmark_pkg::point_t           s1_pt_q;
  logic [rmark_pkg::ROW_W-1:0] s1_row_q;
  logic [CW-1:0]               s1_col_q;
  logic                        s1_row_end_q, s1_bottom_q, s1_fwd_q;
  rmark_pkg::point_t           fwd_data_q;
  logic                        s1_fire, s1_has_res, s1_wr;
  logic                        row_nz, col_nz;

  rmark_pkg::point_t           left_upper_q, left_upper_d;
  rmark_pkg::point_t           left_lower_q, left_lower_d;
  rmark_pkg::point_t           ul, ur, ll, lr, ur_raw;
  logic signed [rmark_pkg::ELEV_W-1:0] m01, m012, wmax;
  logic                        all_present;

  // deferred write of the last column
  logic                        def_pend_q, def_pend_d;
  logic [CW-1:0]               def_addr_q;
  rmark_pkg::point_t           def_data_q;

  // line store port
  logic                        wr_en;
  logic [CW-1:0]               wr_addr;
  rmark_pkg::point_t           wr_data;
  logic [PW-1:0]               ram_rdata;
  logic                        fwd_hit;

  // result buffer
  logic [3:0]                  buf_mask_q, buf_mask_d;
  logic [3:0]                  buf_flag_q;
  logic [rmark_pkg::ROW_W-1:0] buf_row_q;
  logic [CW-1:0]               buf_col_q;
  logic                        buf_free, buf_load, out_fire;
  rmark_pkg::slot_e            sel;
  logic [3:0]                  sel_bit;

  // configuration decode
  always_comb begin
    gw_d    = gw_q;
    gh_d    = gh_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (rmark_pkg::cfg_idx_e'(cfg_idx_i))
        rmark_pkg::CFG_GRID_WIDTH: begin
          gw_d    = cfg_data_i[rmark_pkg::GW_W-1:0];
          restart = 1'b1;
        end
        rmark_pkg::CFG_GRID_HEIGHT: begin
          gh_d    = cfg_data_i[rmark_pkg::GH_W-1:0];
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  assign gw_ext = WW'(gw_q);
  always_comb begin
    if (gw_ext < WW'(2)) begin
      eff_w = WW'(2);
    end else if (gw_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = gw_ext;
    end
  end
  assign last_col = CW'(eff_w - WW'(1));
  assign last_row = (gh_q < rmark_pkg::GH_MIN) ? rmark_pkg::GH_MIN - 1'b1 : gh_q - 1'b1;

  // input side
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_row_end = (col_q == last_col);
  assign in_bottom  = (row_q == last_row);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (in_row_end) begin
        col_d = '0;
        row_d = in_bottom ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // window evaluation
  assign row_nz     = (s1_row_q != '0);
  assign col_nz     = (s1_col_q != '0);
  assign s1_has_res = row_nz && col_nz;
  assign ur_raw     = s1_fwd_q ? fwd_data_q : rmark_pkg::point_t'(ram_rdata);

  always_comb begin
    ul = left_upper_q;
    ll = left_lower_q;
    ur = row_nz ? ur_raw : '0;
    lr = rmark_pkg::point_t'({s1_pt_q.elevation, s1_pt_q.present, 1'b0});
    all_present = ul.present && ur.present && ll.present && lr.present && row_nz && col_nz;
    m01  = (ur.elevation > ul.elevation) ? ur.elevation : ul.elevation;
    m012 = (ll.elevation > m01) ? ll.elevation : m01;
    wmax = (lr.elevation > m012) ? lr.elevation : m012;
    if (all_present) begin
      ul.flag = ul.flag || (ul.elevation == wmax);
      ur.flag = ur.flag || (ur.elevation == wmax);
      ll.flag = ll.flag || (ll.elevation == wmax);
      lr.flag = lr.flag || (lr.elevation == wmax);
    end
  end

  always_comb begin
    left_upper_d = left_upper_q;
    left_lower_d = left_lower_q;
    if (s1_fire) begin
      if (!col_nz) begin
        if (row_nz) begin
          left_upper_d = ur_raw;
        end
        left_lower_d = lr;
      end else begin
        left_upper_d = ur;
        left_lower_d = lr;
      end
    end
  end

  assign s1_fire    = s1_valid_q && (!s1_has_res || buf_free);
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_fire);
  assign s1_wr      = s1_fire && col_nz;
  assign def_pend_d = s1_fire && s1_row_end_q;

  // line store access
  always_comb begin
    if (def_pend_q) begin
      wr_en   = 1'b1;
      wr_addr = def_addr_q;
      wr_data = def_data_q;
    end else begin
      wr_en   = s1_wr;
      wr_addr = s1_col_q - 1'b1;
      wr_data = ll;
    end
  end
  assign fwd_hit = wr_en && (wr_addr == col_q);

  rmark_ram #(
    .Width (PW),
    .Depth (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // result buffer
  assign out_fire = out_o.valid && out_o.ready;
  assign buf_free = (buf_mask_q == '0) || (out_o.ready && $onehot(buf_mask_q));
  assign buf_load = s1_fire && s1_has_res;

  always_comb begin
    if (buf_mask_q[0]) begin
      sel = rmark_pkg::SLOT_UP_LEFT;
    end else if (buf_mask_q[1]) begin
      sel = rmark_pkg::SLOT_UP_RIGHT;
    end else if (buf_mask_q[2]) begin
      sel = rmark_pkg::SLOT_LOW_LEFT;
    end else begin
      sel = rmark_pkg::SLOT_LOW_RIGHT;
    end
  end
  assign sel_bit = 4'b0001 << sel;

  always_comb begin
    buf_mask_d = buf_mask_q;
    if (buf_load) begin
      buf_mask_d = {s1_bottom_q && s1_row_end_q, s1_bottom_q, s1_row_end_q, 1'b1};
    end else if (out_fire) begin
      buf_mask_d = buf_mask_q & ~sel_bit;
    end
  end

  assign out_o.valid      = (buf_mask_q != '0);
  assign out_o.row        = sel[1] ? buf_row_q : buf_row_q - 1'b1;
  assign out_o.column     = rmark_pkg::COL_W'(sel[0] ? buf_col_q : buf_col_q - 1'b1);
  assign out_o.ridge_flag = buf_flag_q[sel];
  assign out_o.last       = (sel == rmark_pkg::SLOT_LOW_RIGHT);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q         <= rmark_pkg::GW_RESET;
      gh_q         <= rmark_pkg::GH_RESET;
      col_q        <= '0;
      row_q        <= '0;
      s1_valid_q   <= 1'b0;
      def_pend_q   <= 1'b0;
      buf_mask_q   <= '0;
      left_upper_q <= '0;
      left_lower_q <= '0;
    end else begin
      gw_q         <= gw_d;
      gh_q         <= gh_d;
      col_q        <= col_d;
      row_q        <= row_d;
      s1_valid_q   <= s1_valid_d;
      def_pend_q   <= def_pend_d;
      buf_mask_q   <= buf_mask_d;
      left_upper_q <= left_upper_d;
      left_lower_q <= left_lower_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pt_q      <= rmark_pkg::point_t'({in_i.elevation, in_i.present, 1'b0});
      s1_row_q     <= row_q;
      s1_col_q     <= col_q;
      s1_row_end_q <= in_row_end;
      s1_bottom_q  <= in_bottom;
      s1_fwd_q     <= fwd_hit;
      fwd_data_q   <= wr_data;
    end
    if (def_pend_d) begin
      def_addr_q <= s1_col_q;
      def_data_q <= lr;
    end
    if (buf_load) begin
      buf_row_q  <= s1_row_q;
      buf_col_q  <= s1_col_q;
      buf_flag_q <= {lr.flag, ll.flag, ur.flag, ul.flag};
    end
  end

  `RMARK_ASSERT(a_one_writer, !(s1_wr && def_pend_q))
  `RMARK_ASSERT_NEXT(a_defer_single, def_pend_q, !def_pend_q)
  `RMARK_ASSERT_NOW(a_last_drains, out_o.valid && out_o.last, $onehot(buf_mask_q))
  `RMARK_ASSERT_NOW(a_load_when_free, buf_load, buf_mask_q == '0 || (out_fire && $onehot(buf_mask_q)))

endmodule

// ----- rtl/rmark_ram.sv -----
// generic single write port ram with registered read, old data on collision
// no dependencies
module rmark_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for the 2x2 ridge marker: streams samples, predicts each mark
// depends on rmark_pkg, rmark_in_if, rmark_out_if and ridge_mark_2x2_window
module testbench;

  localparam logic [rmark_pkg::CFG_IDX_W-1:0] CFG_UNLISTED = 2'd3;

  typedef struct packed {
    logic signed [rmark_pkg::ELEV_W-1:0] elevation;
    logic                                present;
  } sample_t;

  typedef struct packed {
    logic [rmark_pkg::ROW_W-1:0] row;
    logic [rmark_pkg::COL_W-1:0] column;
    logic                        ridge_flag;
    logic                        last;
  } mark_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [rmark_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [rmark_pkg::CFG_DATA_W-1:0] cfg_data_i;

  rmark_in_if  in_if ();
  rmark_out_if out_if ();

  ridge_mark_2x2_window uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  sample_t pending_samples[$];
  mark_t   expected_marks[$];
  sample_t next_sample;
  mark_t   want_mark;
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  // predictor state
  logic [rmark_pkg::GW_W-1:0]  grid_w;
  logic [rmark_pkg::GH_W-1:0]  grid_h;
  logic [rmark_pkg::ROW_W-1:0] row_cnt;
  logic [rmark_pkg::COL_W-1:0] col_cnt;
  rmark_pkg::point_t           left_up;
  rmark_pkg::point_t           left_low;
  rmark_pkg::point_t           line_pts [rmark_pkg::MAX_WIDTH_DEF];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic add_mark(input int r, input int c, input logic f, input logic l);
    mark_t mk;
    mk = '{row: rmark_pkg::ROW_W'(r), column: rmark_pkg::COL_W'(c),
           ridge_flag: f, last: l};
    expected_marks = {expected_marks, mk};
  endtask

  task automatic apply_config(input logic [rmark_pkg::CFG_IDX_W-1:0] idx,
                              input logic [rmark_pkg::CFG_DATA_W-1:0] data);
    if (idx == rmark_pkg::CFG_GRID_WIDTH) begin
      grid_w = data[rmark_pkg::GW_W-1:0];
      row_cnt = '0;
      col_cnt = '0;
    end else if (idx == rmark_pkg::CFG_GRID_HEIGHT) begin
      grid_h = data[rmark_pkg::GH_W-1:0];
      row_cnt = '0;
      col_cnt = '0;
    end
  endtask

  task automatic predict_marks(input logic signed [rmark_pkg::ELEV_W-1:0] elev,
                               input logic pres);
    int unsigned w, h, r, c;
    logic bottom, row_end;
    logic signed [rmark_pkg::ELEV_W-1:0] m;
    rmark_pkg::point_t cur, ul, ur, ll, lr;
    w = 32'(grid_w);
    if (w < 2) w = 2;
    if (w > rmark_pkg::MAX_WIDTH_DEF) w = rmark_pkg::MAX_WIDTH_DEF;
    h = 32'(grid_h);
    if (h < 2) h = 2;
    r = 32'(row_cnt);
    c = 32'(col_cnt);
    bottom = (r == h - 1);
    row_end = (c == w - 1);
    cur = '{elevation: elev, present: pres, flag: 1'b0};
    if (c == 0) begin
      if (r >= 1) left_up = line_pts[0];
      left_low = cur;
    end else begin
      ul = left_up;
      ll = left_low;
      lr = cur;
      ur = '0;
      if (r >= 1) begin
        ur = line_pts[c];
        if (ul.present && ur.present && ll.present && lr.present) begin
          m = ul.elevation;
          if (ur.elevation > m) m = ur.elevation;
          if (ll.elevation > m) m = ll.elevation;
          if (lr.elevation > m) m = lr.elevation;
          if (ul.elevation == m) ul.flag = 1'b1;
          if (ur.elevation == m) ur.flag = 1'b1;
          if (ll.elevation == m) ll.flag = 1'b1;
          if (lr.elevation == m) lr.flag = 1'b1;
        end
        add_mark(r - 1, c - 1, ul.flag, 1'b0);
        if (row_end) add_mark(r - 1, c, ur.flag, 1'b0);
        if (bottom) begin
          add_mark(r, c - 1, ll.flag, 1'b0);
          if (row_end) add_mark(r, c, lr.flag, 1'b1);
        end
      end
      line_pts[c-1] = ll;
      if (row_end) line_pts[c] = lr;
      left_up = ur;
      left_low = lr;
    end
    if (c >= w - 1) begin
      col_cnt = '0;
      row_cnt = (r >= h - 1) ? '0 : rmark_pkg::ROW_W'(r + 1);
    end else begin
      col_cnt = rmark_pkg::COL_W'(c + 1);
    end
  endtask

  // sample driver and predictor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      grid_w = rmark_pkg::GW_RESET;
      grid_h = rmark_pkg::GH_RESET;
      row_cnt = '0;
      col_cnt = '0;
      left_up = '0;
      left_low = '0;
    end else begin
      if (cfg_we_i) apply_config(cfg_idx_i, cfg_data_i);
      if (in_if.valid && in_if.ready) predict_marks(in_if.elevation, in_if.present);
      if (!in_if.valid || in_if.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_sample = pending_samples.pop_front();
          in_if.valid <= 1'b1;
          in_if.elevation <= next_sample.elevation;
          in_if.present <= next_sample.present;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_if.valid && out_if.ready) begin
        if (expected_marks.size() == 0) begin
          $error("unexpected result at row %0d column %0d", out_if.row, out_if.column);
          mismatches++;
        end else begin
          want_mark = expected_marks.pop_front();
          if (out_if.row !== want_mark.row) begin
            $error("row: expected %0d, got %0d", want_mark.row, out_if.row);
            mismatches++;
          end
          if (out_if.column !== want_mark.column) begin
            $error("column: expected %0d, got %0d", want_mark.column, out_if.column);
            mismatches++;
          end
          if (out_if.ridge_flag !== want_mark.ridge_flag) begin
            $error("ridge_flag: expected %0b, got %0b", want_mark.ridge_flag,
                   out_if.ridge_flag);
            mismatches++;
          end
          if (out_if.last !== want_mark.last) begin
            $error("last: expected %0b, got %0b", want_mark.last, out_if.last);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic logic signed [rmark_pkg::ELEV_W-1:0] pick_elevation();
    int v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        v = $urandom_range(0, 4) - 2;
        return v * 65536;
      end
      4: return 32'sh7FFF_FFFF;
      5: return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_sample(input logic signed [rmark_pkg::ELEV_W-1:0] elev,
                             input logic pres);
    sample_t s;
    s = '{elevation: elev, present: pres};
    pending_samples = {pending_samples, s};
  endtask

  task automatic write_reg(input logic [rmark_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rmark_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // all requests taken, all marks seen, then the pipeline is left to settle
  task automatic drain();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || in_if.valid || expected_marks.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_idle(input int s, input int r);
    @(negedge clk_i);
    send_idle_pct = s;
    recv_idle_pct = r;
  endtask

  task automatic random_phase(input logic [rmark_pkg::CFG_DATA_W-1:0] wd,
                              input logic [rmark_pkg::CFG_DATA_W-1:0] hd,
                              input int count);
    write_reg(rmark_pkg::CFG_GRID_WIDTH, wd);
    write_reg(rmark_pkg::CFG_GRID_HEIGHT, hd);
    repeat (count) push_sample(pick_elevation(), $urandom_range(0, 9) != 0);
    drain();
  endtask

  initial begin
    int wd, hd, w_eff, h_eff, n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = rmark_pkg::CFG_GRID_WIDTH;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.elevation = '0;
    in_if.present = 1'b0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idle(37, 81);

    // width and height below range clamp to a 2x2 grid
    write_reg(rmark_pkg::CFG_GRID_WIDTH, 16'h0000);
    write_reg(rmark_pkg::CFG_GRID_HEIGHT, 16'h0001);
    // four-way tie
    repeat (4) push_sample(32'sh0001_0000, 1'b1);
    // single peak over the most negative value
    push_sample(32'sh8000_0000, 1'b1);
    push_sample(32'sh8000_0000, 1'b1);
    push_sample(32'sh8000_0000, 1'b1);
    push_sample(32'sh7FFF_FFFF, 1'b1);
    // missing point breaks the window
    push_sample(32'sh8000_0000, 1'b1);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh0000_0000, 1'b1);
    push_sample(32'sh0000_0000, 1'b1);
    drain();

    // upper register bits ignored, width 3
    write_reg(rmark_pkg::CFG_GRID_WIDTH, 16'hF803);
    write_reg(rmark_pkg::CFG_GRID_HEIGHT, 16'h0003);
    push_sample(32'shFFFF_0000, 1'b1);
    push_sample(32'sh0002_0000, 1'b1);
    push_sample(32'sh0002_0000, 1'b1);
    push_sample(32'sh0002_0000, 1'b1);
    drain();
    // unlisted index must not restart the grid
    write_reg(CFG_UNLISTED, 16'h0002);
    push_sample(32'sh0000_0000, 1'b1);
    push_sample(32'sh8000_0000, 1'b1);
    push_sample(32'sh0000_8000, 1'b1);
    push_sample(32'sh0000_8000, 1'b1);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p == 4) set_idle(81, 37);
      if (p == 8) set_idle(0, 0);
      case ($urandom_range(0, 9))
        0: wd = $urandom_range(0, 1);
        1: wd = 16'hF800 | $urandom_range(2, 6);
        default: wd = $urandom_range(2, 7);
      endcase
      case ($urandom_range(0, 9))
        0: hd = $urandom_range(0, 1);
        1: hd = 16'hFFFF;
        default: hd = $urandom_range(2, 5);
      endcase
      w_eff = wd & 16'h07FF;
      if (w_eff < 2) w_eff = 2;
      if (w_eff > rmark_pkg::MAX_WIDTH_DEF) w_eff = rmark_pkg::MAX_WIDTH_DEF;
      h_eff = (hd < 2) ? 2 : hd;
      if (hd == 16'hFFFF) n = w_eff * $urandom_range(3, 6);
      else n = w_eff * h_eff + $urandom_range(0, w_eff);
      random_phase(wd[rmark_pkg::CFG_DATA_W-1:0], hd[rmark_pkg::CFG_DATA_W-1:0], n);
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rmark_pkg.sv
rtl/rmark_in_if.sv
rtl/rmark_out_if.sv
rtl/rmark_ram.sv
rtl/ridge_mark_2x2_window.sv
bench/testbench.sv
